[rtl/sfm_pkg.sv]
// ----------------------------------------------------------------------------
// sfm_pkg
// Shared types and constants of the first-match substring search block.
// ----------------------------------------------------------------------------
package sfm_pkg;

    // Defaults for the top-level parameters
    localparam int SFM_PATTERN_MAX   = 16;
    localparam int SFM_POSITION_BITS = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_REG_W   = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    // Stream payloads
    localparam int BYTE_W        = 8;
    localparam int IN_TDATA_W    = 8;
    localparam int MATCH_START_W = 16;
    localparam int OUT_TDATA_W   = 24;

    // String terminator
    localparam logic [BYTE_W-1:0] TEXT_END = 8'h00;

    // Control handed to every window cell
    typedef struct packed {
        logic shift;   // take the neighbor's byte
        logic clear;   // drop the window contents
    } cell_ctl_t;

endpackage

[rtl/sfm_cell.sv]
// ----------------------------------------------------------------------------
// sfm_cell
// One window cell: holds one text byte, passes it to the next cell and
// compares the byte it is taking against its aligned pattern byte.
// ----------------------------------------------------------------------------
module sfm_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sfm_pkg::cell_ctl_t      ctl,
    input  logic [7:0]              byte_in,
    input  logic [7:0]              pat_byte,
    input  logic                    care,
    output logic [7:0]              byte_out,
    output logic                    hit
);
    import sfm_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (ctl.clear) begin
            byte_next = '0;
        end else if (ctl.shift) begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    // Compare the incoming byte, i.e. the window as it stands after the shift
    assign hit      = !care || (byte_in == pat_byte);
    assign byte_out = byte_reg;

endmodule

[rtl/sfm_pattern.sv]
// ----------------------------------------------------------------------------
// sfm_pattern
// Configuration registers and the aligned pattern seen by the window cells.
// ----------------------------------------------------------------------------
module sfm_pattern #(
    parameter int PATTERN_MAX = sfm_pkg::SFM_PATTERN_MAX,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sfm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output logic [7:0]                      pat_aligned [PATTERN_MAX],
    output logic [PATTERN_MAX-1:0]          care,
    output logic [LEN_W-1:0]                eff_len
);
    import sfm_pkg::*;

    logic [CFG_DATA_W-1:0]   lo_reg, lo_next;
    logic [CFG_DATA_W-1:0]   hi_reg, hi_next;
    logic [LEN_REG_W-1:0]    len_reg, len_next;
    logic [2*CFG_DATA_W-1:0] all_bytes;
    logic [LEN_W-1:0]        cap;
    logic [LEN_W-1:0]        eff_next;
    logic [BYTE_W-1:0]       al_next  [PATTERN_MAX];
    logic [BYTE_W-1:0]       al_reg   [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]  care_next, care_reg;
    logic [LEN_W-1:0]        eff_reg;

    always_comb begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        len_next = len_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_PATTERN_LOW:  lo_next  = cfg_wdata;
                REG_PATTERN_HIGH: hi_next  = cfg_wdata;
                REG_PATTERN_LEN:  len_next = cfg_wdata[LEN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective length: capped, then cut at the first zero pattern byte
    always_comb begin
        all_bytes = {hi_next, lo_next};
        if (int'(len_next) > PATTERN_MAX) begin
            cap = LEN_W'(PATTERN_MAX);
        end else begin
            cap = LEN_W'(len_next);
        end
        eff_next = cap;
        for (int j = PATTERN_MAX - 1; j >= 0; j--) begin
            if (j < int'(cap) && all_bytes[BYTE_W*j +: BYTE_W] == TEXT_END) begin
                eff_next = LEN_W'(j);
            end
        end
    end

    // Cell k sees the byte received k items ago, so it checks pattern byte
    // eff_len-1-k
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            al_next[k]   = '0;
            care_next[k] = (k < int'(eff_next));
            for (int j = 0; j < PATTERN_MAX; j++) begin
                if (j + k + 1 == int'(eff_next)) begin
                    al_next[k] = all_bytes[BYTE_W*j +: BYTE_W];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg   <= '0;
            hi_reg   <= '0;
            len_reg  <= '0;
            eff_reg  <= '0;
            care_reg <= '0;
            for (int k = 0; k < PATTERN_MAX; k++) begin
                al_reg[k] <= '0;
            end
        end else begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            len_reg  <= len_next;
            eff_reg  <= eff_next;
            care_reg <= care_next;
            for (int k = 0; k < PATTERN_MAX; k++) begin
                al_reg[k] <= al_next[k];
            end
        end
    end

    assign pat_aligned = al_reg;
    assign care        = care_reg;
    assign eff_len     = eff_reg;

endmodule

[rtl/substring_first_match_search.sv]
// ----------------------------------------------------------------------------
// substring_first_match_search
// Streams a zero-terminated text one byte per item through a row of window
// cells and reports where a configured pattern of up to 16 bytes first starts.
// ----------------------------------------------------------------------------
// Throughput: one text byte per cycle while s_tready is high; the row of window
//   cells compares the whole window in the cycle a byte is taken.
// The result is registered and shows on m_tvalid in the cycle after the terminator item.
// s_tready drops only while a result waits in the output register and
//   m_tready is low.
// Reset (aresetn low, synchronous) clears the pattern registers, the window,
//   the byte count, the match record and the output register.
// ----------------------------------------------------------------------------
module substring_first_match_search #(
    parameter int PATTERN_MAX   = sfm_pkg::SFM_PATTERN_MAX,   // 1..16
    parameter int POSITION_BITS = sfm_pkg::SFM_POSITION_BITS  // 8..32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [sfm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Text input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sfm_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] text_byte
    // Result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sfm_pkg::OUT_TDATA_W-1:0] m_tdata    // [0] found,
                                                       // [16:1] match_start,
                                                       // [17] too_long, [23:18] zero
);
    import sfm_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int EXT_W = (POSITION_BITS > MATCH_START_W) ? POSITION_BITS : MATCH_START_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // Aligned pattern from the configuration block
    logic [BYTE_W-1:0]      pat_aligned [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] care;
    logic [LEN_W-1:0]       eff_len;

    // Window cell row
    cell_ctl_t              cell_ctl;
    logic [BYTE_W-1:0]      cell_in  [PATTERN_MAX];
    logic [BYTE_W-1:0]      cell_out [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_hit;
    logic                   window_hit;

    // Handshake
    logic                   in_accept;
    logic                   is_end;

    // Stream state
    logic [POSITION_BITS-1:0] bytes_seen_reg, bytes_seen_next;
    logic                     overflow_reg, overflow_next;
    logic                     match_reg, match_next;
    logic [POSITION_BITS-1:0] offset_reg, offset_next;
    logic [POSITION_BITS:0]   pos_plus_one;
    logic [POSITION_BITS:0]   start_calc;

    // Output register
    logic                     m_valid_reg, m_valid_next;
    logic                     m_found_reg, m_found_next;
    logic [MATCH_START_W-1:0] m_start_reg, m_start_next;
    logic                     m_long_reg, m_long_next;
    logic [EXT_W-1:0]         offset_ext;

    sfm_pattern #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_pattern (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .pat_aligned (pat_aligned),
        .care        (care),
        .eff_len     (eff_len)
    );

    // Take a new item unless a finished result is stuck in the output register
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign is_end    = (s_tdata[BYTE_W-1:0] == TEXT_END);

    // Shift on every text byte; drop the window at the terminator
    assign cell_ctl.shift = in_accept && !is_end;
    assign cell_ctl.clear = in_accept && is_end;

    // Cell 0 takes the new byte, every other cell its left neighbor's byte
    always_comb begin
        cell_in[0] = s_tdata[BYTE_W-1:0];
        for (int k = 1; k < PATTERN_MAX; k++) begin
            cell_in[k] = cell_out[k-1];
        end
    end

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        sfm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (cell_ctl),
            .byte_in  (cell_in[k]),
            .pat_byte (pat_aligned[k]),
            .care     (care[k]),
            .byte_out (cell_out[k]),
            .hit      (cell_hit[k])
        );
    end

    // Cells beyond the pattern length always report a hit
    assign window_hit = &cell_hit;

    // Start of the match ending at this byte; pinned at zero if it would go
    // below the text start
    assign pos_plus_one = {1'b0, bytes_seen_reg} + (POSITION_BITS + 1)'(1);
    always_comb begin
        if (pos_plus_one >= (POSITION_BITS + 1)'(eff_len)) begin
            start_calc = pos_plus_one - (POSITION_BITS + 1)'(eff_len);
        end else begin
            start_calc = '0;
        end
    end

    // Stream state: count, saturate, record the first match
    always_comb begin
        bytes_seen_next = bytes_seen_reg;
        overflow_next   = overflow_reg;
        match_next      = match_reg;
        offset_next     = offset_reg;
        if (cell_ctl.clear) begin
            bytes_seen_next = '0;
            overflow_next   = 1'b0;
            match_next      = 1'b0;
            offset_next     = '0;
        end else if (cell_ctl.shift) begin
            if (bytes_seen_reg != POS_MAX) begin
                bytes_seen_next = bytes_seen_reg + 1'b1;
            end else begin
                overflow_next = 1'b1;
            end
            if (!match_reg) begin
                if (eff_len == '0) begin
                    // Empty pattern matches at the text start
                    match_next  = 1'b1;
                    offset_next = '0;
                end else if (window_hit) begin
                    match_next  = 1'b1;
                    offset_next = start_calc[POSITION_BITS-1:0];
                end
            end
        end
    end

    // Output register: load at the terminator, hold until taken
    assign offset_ext = EXT_W'(offset_reg);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_start_next = m_start_reg;
        m_long_next  = m_long_reg;
        if (cell_ctl.clear) begin
            m_valid_next = 1'b1;
            m_found_next = match_reg;
            m_start_next = match_reg ? offset_ext[MATCH_START_W-1:0] : '0;
            m_long_next  = overflow_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg <= '0;
            overflow_reg   <= 1'b0;
            match_reg      <= 1'b0;
            offset_reg     <= '0;
            m_valid_reg    <= 1'b0;
            m_found_reg    <= 1'b0;
            m_start_reg    <= '0;
            m_long_reg     <= 1'b0;
        end else begin
            bytes_seen_reg <= bytes_seen_next;
            overflow_reg   <= overflow_next;
            match_reg      <= match_next;
            offset_reg     <= offset_next;
            m_valid_reg    <= m_valid_next;
            m_found_reg    <= m_found_next;
            m_start_reg    <= m_start_next;
            m_long_reg     <= m_long_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - MATCH_START_W - 2)'(0), m_long_reg, m_start_reg,
                       m_found_reg};

    // A terminator always leaves a result waiting in the next cycle
    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_ctl.clear |=> m_valid_reg)
        else $error("terminator did not produce a result");

    // The stream state is empty after a terminator
    a_end_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_ctl.clear |=> (bytes_seen_reg == '0) && !match_reg && !overflow_reg)
        else $error("stream state not cleared after terminator");

    // A recorded match holds until the string ends
    a_match_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (match_reg && !cell_ctl.clear) |=> match_reg && $stable(offset_reg))
        else $error("recorded match changed within a string");

    // Overflow is only flagged once the byte count has saturated
    a_overflow_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> (bytes_seen_reg == POS_MAX))
        else $error("overflow flagged below counter saturation");

    // No match start is reported without a match
    a_start_needs_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_start_reg == '0))
        else $error("match start reported without a match");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-match substring search. A queue-fed driver
// streams zero-terminated texts, a bit-exact search predictor works out the
// result of every terminator, and a monitor checks each result field by field.
// Covers empty texts and patterns, cut-short and capped patterns, pattern
// changes in the middle of a text and output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfm_pkg::*;

    localparam int PAT_MAX   = SFM_PATTERN_MAX;
    localparam int POS_LIMIT = (1 << SFM_POSITION_BITS) - 1;
    // Index past the register list: writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int REPORT_LIMIT   = 20;

    // Result fields, found in the lowest bit
    typedef struct packed {
        logic                     too_long;
        logic [MATCH_START_W-1:0] match_start;
        logic                     found;
    } search_result_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;     // [7:0] text_byte
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;            // [0] found, [16:1] match_start,
                                                // [17] too_long, [23:18] zero

    substring_first_match_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow of the pattern registers and of the search state
    // ------------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] pat_low_q  = '0;
    logic [CFG_DATA_W-1:0] pat_high_q = '0;
    logic [LEN_REG_W-1:0]  pat_len_q  = '0;

    logic [BYTE_W-1:0] window_q [PAT_MAX];   // window_q[k]: byte taken k items ago
    int                count_q;
    bit                saturated_q;
    bit                hit_q;
    int                hit_at_q;

    search_result_t results_due [$];     // predicted results, oldest first
    logic [BYTE_W-1:0] text_q [$];       // text items waiting for the driver

    int mismatches;
    int items_queued;
    int strings_queued;
    int settings_used;
    int results_seen;
    int matches_seen;
    int saturations_seen;

    // Flags from the stimulus process to the clocked drivers
    logic idle_on     = 1'b1;
    logic squeeze_req = 1'b0;
    bit   squeeze_done;

    function automatic logic [BYTE_W-1:0] pattern_byte(input int j);
        if (j < 8)
            return pat_low_q[8*j +: 8];
        return pat_high_q[8*(j-8) +: 8];
    endfunction

    // Length in use: capped at the window size, cut at the first zero byte
    function automatic int live_pattern_len();
        int n;
        int j;
        n = pat_len_q;
        if (n > PAT_MAX)
            n = PAT_MAX;
        for (j = 0; j < n; j++)
            if (pattern_byte(j) == TEXT_END)
                return j;
        return n;
    endfunction

    function automatic void forget_text();
        int k;
        for (k = 0; k < PAT_MAX; k++)
            window_q[k] = '0;
        count_q     = 0;
        saturated_q = 1'b0;
        hit_q       = 1'b0;
        hit_at_q    = 0;
    endfunction

    // Advance the search by one text byte; returns 1 when the byte ends a text
    // and a result is due.
    function automatic bit scan_text_byte(input logic [BYTE_W-1:0] b,
                                          output search_result_t r);
        int  n;
        int  j;
        int  pos;
        bit  hit;
        r = '0;
        if (b == TEXT_END) begin
            r.found       = hit_q;
            r.match_start = hit_q ? hit_at_q[MATCH_START_W-1:0] : '0;
            r.too_long    = saturated_q;
            forget_text();
            return 1'b1;
        end
        // position of this byte; it sticks at the counter top once saturated
        pos = count_q;
        if (count_q < POS_LIMIT)
            count_q++;
        else
            saturated_q = 1'b1;
        for (j = PAT_MAX - 1; j > 0; j--)
            window_q[j] = window_q[j-1];
        window_q[0] = b;
        if (!hit_q) begin
            n = live_pattern_len();
            if (n == 0) begin
                // empty pattern hits at the first byte
                hit_q    = 1'b1;
                hit_at_q = 0;
            end else begin
                hit = 1'b1;
                for (j = 0; j < n; j++)
                    if (window_q[n-1-j] != pattern_byte(j))
                        hit = 1'b0;
                if (hit) begin
                    hit_q    = 1'b1;
                    hit_at_q = (pos + 1 >= n) ? pos + 1 - n : 0;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic void note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer queued text bytes, with random idle bursts
    // ------------------------------------------------------------------------
    int send_hold;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            send_hold = 0;
        end else if (!s_tvalid || s_tready) begin
            // slot is free: the item on the bus (if any) was taken at this edge
            if (send_hold > 0) begin
                send_hold--;
                s_tvalid <= 1'b0;
            end else if (text_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                send_hold = $urandom_range(0, 14);
                s_tvalid  <= 1'b0;
            end else begin
                s_tdata  <= text_q.pop_front();
                s_tvalid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready bursts, plus one long hold-off on request
    // ------------------------------------------------------------------------
    int take_hold;
    int squeeze_count;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready      <= 1'b0;
            take_hold     = 0;
            squeeze_count = 0;
        end else if (squeeze_req && !squeeze_done) begin
            // hold ready low so a result parks and the input backs up
            m_tready <= 1'b0;
            squeeze_count++;
            if (squeeze_count >= SQUEEZE_CYCLES)
                squeeze_done = 1'b1;
        end else if (take_hold > 0) begin
            take_hold--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            take_hold = $urandom_range(0, 14);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check results against the oldest prediction, then predict
    // from the item taken at this edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        search_result_t got;
        search_result_t want;
        search_result_t predicted;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(search_result_t)-1:0];
                results_seen++;
                if (results_due.size() == 0) begin
                    note_mismatch("unexpected result, found flag", -1, got.found);
                end else begin
                    want = results_due.pop_front();
                    if (want.found)
                        matches_seen++;
                    if (want.too_long)
                        saturations_seen++;
                    if (got.found !== want.found)
                        note_mismatch("found", want.found, got.found);
                    if (got.match_start !== want.match_start)
                        note_mismatch("match_start", want.match_start, got.match_start);
                    if (got.too_long !== want.too_long)
                        note_mismatch("too_long", want.too_long, got.too_long);
                end
            end
            if (s_tvalid && s_tready && scan_text_byte(s_tdata, predicted))
                results_due.push_back(predicted);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        text_q.push_back(b);
        items_queued++;
        if (b == TEXT_END)
            strings_queued++;
    endtask

    task automatic push_chars(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // Wait until the block is idle: nothing queued, nothing offered, nothing due
    task automatic settle();
        @(posedge aclk);
        while (text_q.size() != 0 || s_tvalid || results_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write one register; the shadow copy follows at the write edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (index)
            REG_PATTERN_LOW:  pat_low_q  = value;
            REG_PATTERN_HIGH: pat_high_q = value;
            REG_PATTERN_LEN:  pat_len_q  = value[LEN_REG_W-1:0];
            default: ;
        endcase
    endtask

    // Pattern bytes: often a tiny alphabet, else any nonzero byte, now and then zero
    function automatic logic [BYTE_W-1:0] pick_pattern_byte();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return TEXT_END;
        if (roll < 10)
            return BYTE_W'(8'h61 + $urandom_range(0, 2));
        return BYTE_W'($urandom_range(1, 255));
    endfunction

    // Text bytes: lean on the pattern's own bytes to provoke near misses
    function automatic logic [BYTE_W-1:0] pick_text_byte(input int n);
        if (n > 0 && $urandom_range(0, 9) < 6)
            return pattern_byte($urandom_range(0, n - 1));
        return BYTE_W'($urandom_range(1, 255));
    endfunction

    task automatic shuffle_pattern();
        logic [CFG_DATA_W-1:0] v;
        int roll;
        int j;
        if ($urandom_range(0, 2) != 0) begin
            for (j = 0; j < 8; j++)
                v[8*j +: 8] = pick_pattern_byte();
            write_reg(REG_PATTERN_LOW, v);
        end
        if ($urandom_range(0, 2) != 0) begin
            for (j = 0; j < 8; j++)
                v[8*j +: 8] = pick_pattern_byte();
            write_reg(REG_PATTERN_HIGH, v);
        end
        if ($urandom_range(0, 2) != 0) begin
            // junk above the length field must be dropped
            v    = {$urandom, $urandom};
            roll = $urandom_range(0, 9);
            if (roll == 0)
                v[LEN_REG_W-1:0] = '0;
            else if (roll == 1)
                v[LEN_REG_W-1:0] = LEN_REG_W'(PAT_MAX);
            else if (roll == 2)
                v[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(PAT_MAX + 1, 31));
            else
                v[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(1, 6));
            write_reg(REG_PATTERN_LEN, v);
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNUSED, {$urandom, $urandom});
        settings_used++;
    endtask

    // One text of len bytes, often with the live pattern planted inside
    task automatic push_random_string(input int len);
        logic [BYTE_W-1:0] text [$];
        int n;
        int pos;
        int i;
        n = live_pattern_len();
        for (i = 0; i < len; i++)
            text.push_back(pick_text_byte(n));
        if (n > 0 && n <= len && $urandom_range(0, 9) < 6) begin
            pos = $urandom_range(0, len - n);
            for (i = 0; i < n; i++)
                text[pos + i] = pattern_byte(i);
        end
        for (i = 0; i < len; i++)
            push_byte(text[i]);
        push_byte(TEXT_END);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        forget_text();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        settings_used = 1;

        // Empty pattern after reset: empty text misses, any byte hits at 0
        push_byte(TEXT_END);
        push_chars("A");
        push_byte(TEXT_END);
        settle();

        // Zero byte inside the pattern ends it early: "ab" of length 5
        write_reg(REG_PATTERN_LOW, 64'h0000_0000_6300_6261);
        write_reg(REG_PATTERN_LEN, 64'd5);
        settings_used++;
        push_chars("xab");
        push_byte(TEXT_END);
        settle();

        // Pattern change in the middle of a text: "a" then switch to "cd"
        push_chars("a");
        settle();
        write_reg(REG_PATTERN_LOW, 64'h0000_0000_0000_6463);
        write_reg(REG_UNUSED, '1);
        settings_used++;
        push_chars("bcd");
        push_byte(TEXT_END);
        settle();

        // Widest pattern, all ones, length above the window size (capped)
        write_reg(REG_PATTERN_LOW, '1);
        write_reg(REG_PATTERN_HIGH, '1);
        write_reg(REG_PATTERN_LEN, 64'h8000_0000_0000_001F);
        settings_used++;
        push_byte(8'h01);
        repeat (PAT_MAX) push_byte(8'hFF);
        push_byte(TEXT_END);
        settle();

        // Random phases: new pattern settings, then a batch of texts
        while (items_queued < 1950) begin
            shuffle_pattern();
            if (!squeeze_req && items_queued >= 700) begin
                // park a result and keep offering short texts behind it
                squeeze_req <= 1'b1;
                repeat (12) push_random_string($urandom_range(0, 3));
            end
            if (items_queued >= 1600)
                idle_on <= 1'b0;     // quiet tail: no idling from here on
            repeat ($urandom_range(4, 12)) push_random_string($urandom_range(0, 20));
            settle();
        end
        repeat (10) @(posedge aclk);

        $display("Ran %0d text bytes in %0d texts over %0d pattern settings; %0d results checked.",
                 items_queued, strings_queued, settings_used, results_seen);
        $display("%0d texts held the pattern, %0d ran past the position counter.",
                 matches_seen, saturations_seen);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
rtl/sfm_pkg.sv
rtl/sfm_cell.sv
rtl/sfm_pattern.sv
rtl/substring_first_match_search.sv
tb/tb_top.sv
